FILE: src/udms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package udms_pkg;

    localparam int ADDR_W  = 18;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 16;
    localparam int TICKS_W = 16;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 96;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = TICKS_W'(1000);
    localparam logic [ADDR_W-1:0]  ADDR_STEP     = ADDR_W'(2);

    // word transfer phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DRIVE    = 3'd1,
        PH_SSYN_LOW = 3'd2,
        PH_WAIT_RD  = 3'd3,
        PH_WAIT_WR  = 3'd4,
        PH_FINISH   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_INIT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_START_ADDRESS = 2'd0,
        CFG_WORD_COUNT    = 2'd1,
        CFG_CYCLE_KIND    = 2'd2,
        CFG_TIMEOUT_TICKS = 2'd3
    } cfg_idx_t;

    // cycle_kind bits
    localparam int KIND_BYTE_BIT  = 0;
    localparam int KIND_WRITE_BIT = 1;

    // C1 C0 codes
    localparam logic [1:0] CTL_READ  = 2'd0;
    localparam logic [1:0] CTL_WRITE = 2'd2;

    // internal register write codes
    localparam logic [1:0] IWR_NONE = 2'd0;
    localparam logic [1:0] IWR_WORD = 2'd1;
    localparam logic [1:0] IWR_BYTE = 2'd2;

    localparam logic MODE_START = 1'b1;

endpackage

`default_nettype wire

FILE: src/unibus_dma_master_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// result: each accepted input item yields its result item on the m_ side in the cycle after acceptance
// throughput: one item per cycle; the single result register sets this, and s_tready
//   drops only while a result is held and m_tready is low
// reset: synchronous active-low aresetn; phase idle, status ready, sack and bbsy held,
//   address, counts and index zero, timeout_ticks 1000, other registers zero but the result data, which is not reset

module unibus_dma_master_sequencer_core
    import udms_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] ssyn_in, [1] init_in, [2] internal_hit, [18:3] internal_read_data,
    // [34:19] bus_data_in, [50:35] write_word, [55:51] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic                 s_tuser,

    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [17:0] bus_address, [19:18] bus_control, [20] msyn_out, [36:21] data_lines,
    // [37] sack_out, [38] bbsy_out, [40:39] status, [41] buffer_write,
    // [57:42] buffer_index, [73:58] buffer_data, [75:74] internal_write,
    // [91:76] internal_write_data, [95:92] zero
    output logic [M_TDATA_W-1:0]      m_tdata,

    // register writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // input field unpacking
    // ------------------------------------------------------------------
    logic              in_mode;
    logic              in_ssyn;
    logic              in_init;
    logic              in_hit;
    logic [WORD_W-1:0] in_int_rd;
    logic [WORD_W-1:0] in_bus_rd;
    logic [WORD_W-1:0] in_wword;

    assign in_mode   = s_tuser;
    assign in_ssyn   = s_tdata[0];
    assign in_init   = s_tdata[1];
    assign in_hit    = s_tdata[2];
    assign in_int_rd = s_tdata[18:3];
    assign in_bus_rd = s_tdata[34:19];
    assign in_wword  = s_tdata[50:35];

    // ------------------------------------------------------------------
    // configuration registers, to be written only while idle; the block itself does not enforce this
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  start_addr_reg;
    logic [COUNT_W-1:0] word_count_reg;
    logic [1:0]         cycle_kind_reg;
    logic [TICKS_W-1:0] timeout_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_addr_reg    <= '0;
            word_count_reg    <= '0;
            cycle_kind_reg    <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_ADDRESS: start_addr_reg    <= cfg_data;
                CFG_WORD_COUNT:    word_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_CYCLE_KIND:    cycle_kind_reg    <= cfg_data[1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    logic kind_write;
    logic kind_byte;
    assign kind_write = cycle_kind_reg[KIND_WRITE_BIT];
    assign kind_byte  = cycle_kind_reg[KIND_BYTE_BIT];

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    phase_t             phase_reg,     phase_next;
    logic [ADDR_W-1:0]  word_addr_reg, word_addr_next;
    logic [COUNT_W-1:0] left_reg,      left_next;
    logic [COUNT_W-1:0] index_reg,     index_next;
    logic [TICKS_W-1:0] tcount_reg,    tcount_next;
    logic               timed_reg,     timed_next;
    status_t            status_reg,    status_next;
    logic               sack_reg,      sack_next;
    logic               bbsy_reg,      bbsy_next;

    logic in_accept;
    logic out_valid_reg;

    // skid-free single result stage: take a new item whenever the slot frees up
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    logic [COUNT_W-1:0] left_dec;
    logic               tick_expired;
    logic               wait_done;
    phase_t             wait_phase;

    assign left_dec     = left_reg - COUNT_W'(1);
    assign tick_expired = (tcount_reg <= TICKS_W'(1));
    // a wait phase ends on ssyn or when the tick budget runs out
    assign wait_done    = in_ssyn || tick_expired;
    assign wait_phase   = kind_write ? PH_WAIT_WR : PH_WAIT_RD;

    // next state
    always_comb begin
        phase_next     = phase_reg;
        word_addr_next = word_addr_reg;
        left_next      = left_reg;
        index_next     = index_reg;
        tcount_next    = tcount_reg;
        timed_next     = timed_reg;
        status_next    = status_reg;
        sack_next      = sack_reg;
        bbsy_next      = bbsy_reg;

        if (in_mode == MODE_START) begin
            // start or restart: arbitration counts as won
            word_addr_next = start_addr_reg;
            left_next      = word_count_reg;
            index_next     = '0;
            tcount_next    = '0;
            timed_next     = 1'b0;
            status_next    = ST_RUNNING;
            sack_next      = 1'b1;
            bbsy_next      = 1'b1;
            phase_next     = PH_DRIVE;
        end else begin
            unique case (phase_reg)
                PH_DRIVE: begin
                    if (left_reg == '0) begin
                        sack_next   = 1'b0;
                        bbsy_next   = 1'b0;
                        status_next = ST_READY;
                        phase_next  = PH_IDLE;
                    end else begin
                        // last word: drop sack as it is driven
                        if (left_reg == COUNT_W'(1)) sack_next = 1'b0;
                        timed_next = 1'b0;
                        if (kind_write && in_ssyn) begin
                            phase_next = PH_SSYN_LOW;
                        end else if (in_hit) begin
                            phase_next = PH_FINISH;
                        end else begin
                            tcount_next = timeout_ticks_reg;
                            phase_next  = wait_phase;
                        end
                    end
                end
                PH_SSYN_LOW: begin
                    if (!in_ssyn) begin
                        if (in_hit) begin
                            phase_next = PH_FINISH;
                        end else begin
                            tcount_next = timeout_ticks_reg;
                            phase_next  = PH_WAIT_WR;
                        end
                    end
                end
                PH_WAIT_RD, PH_WAIT_WR: begin
                    if (in_ssyn) begin
                        phase_next = PH_FINISH;
                    end else if (tick_expired) begin
                        timed_next = 1'b1;
                        phase_next = PH_FINISH;
                    end else begin
                        tcount_next = tcount_reg - TICKS_W'(1);
                    end
                end
                PH_FINISH: begin
                    if (timed_reg) begin
                        sack_next   = 1'b0;
                        bbsy_next   = 1'b0;
                        status_next = ST_TIMEOUT;
                        phase_next  = PH_IDLE;
                    end else begin
                        left_next  = left_dec;
                        index_next = index_reg + COUNT_W'(1);
                        if (left_dec == '0) begin
                            // sack already dropped with the last word
                            bbsy_next   = 1'b0;
                            status_next = ST_READY;
                            phase_next  = PH_IDLE;
                        end else if (in_init) begin
                            sack_next   = 1'b0;
                            bbsy_next   = 1'b0;
                            status_next = ST_INIT;
                            phase_next  = PH_IDLE;
                        end else begin
                            word_addr_next = word_addr_reg + ADDR_STEP;
                            phase_next     = PH_DRIVE;
                        end
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // result fields of this tick
    logic [ADDR_W-1:0] r_addr;
    logic [1:0]        r_ctl;
    logic              r_msyn;
    logic [WORD_W-1:0] r_data;
    logic              r_bwr;
    logic [WORD_W-1:0] r_bdata;
    logic [1:0]        r_iwr;
    logic [WORD_W-1:0] r_idata;

    logic [1:0]        ctl_kind;
    logic [WORD_W-1:0] int_wdata;
    logic [1:0]        int_wcode;

    assign ctl_kind  = kind_write ? CTL_WRITE : CTL_READ;
    // byte write picks the upper byte on an odd address
    assign int_wdata = !kind_byte ? in_wword :
                       word_addr_reg[0] ? {8'h00, in_wword[15:8]} : {8'h00, in_wword[7:0]};
    assign int_wcode = kind_byte ? IWR_BYTE : IWR_WORD;

    always_comb begin
        r_addr  = '0;
        r_ctl   = CTL_READ;
        r_msyn  = 1'b0;
        r_data  = '0;
        r_bwr   = 1'b0;
        r_bdata = '0;
        r_iwr   = IWR_NONE;
        r_idata = '0;

        if (in_mode != MODE_START) begin
            unique case (phase_reg)
                PH_DRIVE: begin
                    if (left_reg != '0) begin
                        r_addr = word_addr_reg;
                        r_ctl  = ctl_kind;
                        if (kind_write) begin
                            r_data = in_wword;
                            if (!in_ssyn) begin
                                if (in_hit) begin
                                    r_data  = '0;
                                    r_iwr   = int_wcode;
                                    r_idata = int_wdata;
                                end else begin
                                    r_msyn = 1'b1;
                                end
                            end
                        end else if (in_hit) begin
                            r_bwr   = 1'b1;
                            r_bdata = in_int_rd;
                        end else begin
                            r_msyn = 1'b1;
                        end
                    end
                end
                PH_SSYN_LOW: begin
                    r_addr = word_addr_reg;
                    r_ctl  = CTL_WRITE;
                    r_data = in_wword;
                    if (!in_ssyn) begin
                        if (in_hit) begin
                            r_data  = '0;
                            r_iwr   = int_wcode;
                            r_idata = int_wdata;
                        end else begin
                            r_msyn = 1'b1;
                        end
                    end
                end
                PH_WAIT_RD, PH_WAIT_WR: begin
                    r_addr = word_addr_reg;
                    r_ctl  = (phase_reg == PH_WAIT_WR) ? CTL_WRITE : CTL_READ;
                    if (!wait_done) begin
                        r_msyn = 1'b1;
                        r_data = (phase_reg == PH_WAIT_WR) ? in_wword : '0;
                    end else if (phase_reg == PH_WAIT_RD) begin
                        // a timed-out read still stores the sampled lines
                        r_bwr   = 1'b1;
                        r_bdata = in_bus_rd;
                    end
                end
                PH_FINISH: begin
                    // lines stay driven only when moving on to the next word
                    if (!timed_reg && left_dec != '0 && !in_init) begin
                        r_addr = word_addr_reg;
                        r_ctl  = ctl_kind;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            word_addr_reg <= '0;
            left_reg      <= '0;
            index_reg     <= '0;
            tcount_reg    <= '0;
            timed_reg     <= 1'b0;
            status_reg    <= ST_READY;
            sack_reg      <= 1'b1;
            bbsy_reg      <= 1'b1;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            word_addr_reg <= word_addr_next;
            left_reg      <= left_next;
            index_reg     <= index_next;
            tcount_reg    <= tcount_next;
            timed_reg     <= timed_next;
            status_reg    <= status_next;
            sack_reg      <= sack_next;
            bbsy_reg      <= bbsy_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    assign out_data_next = {4'h0, r_idata, r_iwr, r_bdata, index_next, r_bwr,
                            status_next, bbsy_next, sack_next, r_data, r_msyn,
                            r_ctl, r_addr};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the sequencer is idle exactly when no transfer is running
    a_idle_vs_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) == (status_reg != ST_RUNNING))
        else $error("phase and run status disagree");

    // bbsy is never dropped while sack is still held
    a_bbsy_sack: assert property (@(posedge aclk) disable iff (!aresetn)
        !bbsy_reg |-> !sack_reg)
        else $error("sack held after bbsy dropped");

    // every accepted item leaves a result waiting
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import udms_pkg::*;

    // quiet cycles tolerated before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // cycles to keep watching for stray results once everything has drained
    localparam int unsigned DRAIN_CYCLES = 8;

    // one service tick or start item as it enters the sequencer
    typedef struct packed {
        logic        mode;
        logic        ssyn;
        logic        init;
        logic        hit;
        logic [15:0] ird;
        logic [15:0] bdin;
        logic [15:0] wword;
    } tick_t;

    // bus and buffer lines produced by one tick
    typedef struct packed {
        logic [17:0] addr;
        logic [1:0]  ctl;
        logic        msyn;
        logic [15:0] data;
        logic        sack;
        logic        bbsy;
        logic [1:0]  status;
        logic        bwr;
        logic [15:0] bidx;
        logic [15:0] bdata;
        logic [1:0]  iwr;
        logic [15:0] idata;
    } lines_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data  = '0;

    unibus_dma_master_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // shadow copy of the register file
    logic [17:0] cfg_start;
    logic [15:0] cfg_count;
    logic [1:0]  cfg_kind;
    logic [15:0] cfg_ticks;

    // shadow copy of the sequencer state
    phase_t      seq_phase;
    logic [17:0] word_addr;
    logic [15:0] words_left;
    logic [15:0] word_idx;
    logic [15:0] wait_cnt;
    logic        timed_out;
    status_t     run_st;
    logic        sack_q;
    logic        bbsy_q;

    // bus lines still owed by the sequencer, oldest first
    lines_t      expected_q[$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    // random pacing on both sides, off for some stretches
    logic        idle_on        = 1'b1;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 30);
    endfunction

    // stop the transfer: release address, control, msyn and data, drop bbsy (and sack if asked), set the status
    task automatic release_bus(input status_t st, input logic drop_sack, inout lines_t r);
        r.addr = '0;
        r.ctl  = CTL_READ;
        r.msyn = 1'b0;
        r.data = '0;
        if (drop_sack) sack_q = 1'b0;
        bbsy_q    = 1'b0;
        run_st    = st;
        seq_phase = PH_IDLE;
    endtask

    // msyn step: an internal slave answers at once, an external one is waited for
    task automatic raise_msyn(input logic is_wr, input tick_t t, inout lines_t r);
        if (t.hit) begin
            r.msyn = 1'b0;
            if (is_wr) begin
                r.data = '0;
                if (cfg_kind[KIND_BYTE_BIT]) begin
                    // odd address selects the upper byte
                    r.iwr   = IWR_BYTE;
                    r.idata = word_addr[0] ? {8'h00, t.wword[15:8]} : {8'h00, t.wword[7:0]};
                end else begin
                    r.iwr   = IWR_WORD;
                    r.idata = t.wword;
                end
            end else begin
                r.bwr   = 1'b1;
                r.bdata = t.ird;
            end
            seq_phase = PH_FINISH;
        end else begin
            r.msyn    = 1'b1;
            wait_cnt  = cfg_ticks;
            seq_phase = is_wr ? PH_WAIT_WR : PH_WAIT_RD;
        end
    endtask

    // advance the shadow sequencer by one tick and return the lines it drives
    task automatic predict_bus_lines(input tick_t t, output lines_t r);
        logic wr;
        logic done;
        r = '0;
        if (t.mode) begin
            word_addr  = cfg_start;
            words_left = cfg_count;
            word_idx   = '0;
            wait_cnt   = '0;
            timed_out  = 1'b0;
            run_st     = ST_RUNNING;
            sack_q     = 1'b1;
            bbsy_q     = 1'b1;
            seq_phase  = PH_DRIVE;
        end else begin
            case (seq_phase)
                PH_DRIVE: begin
                    if (words_left == 0) begin
                        release_bus(ST_READY, 1'b1, r);
                    end else begin
                        wr = cfg_kind[KIND_WRITE_BIT];
                        // sack goes away as soon as the last word is on the bus
                        if (words_left == 1) sack_q = 1'b0;
                        timed_out = 1'b0;
                        r.addr    = word_addr;
                        r.ctl     = wr ? CTL_WRITE : CTL_READ;
                        if (wr) begin
                            r.data = t.wword;
                            if (t.ssyn) seq_phase = PH_SSYN_LOW;
                            else raise_msyn(1'b1, t, r);
                        end else begin
                            raise_msyn(1'b0, t, r);
                        end
                    end
                end
                PH_SSYN_LOW: begin
                    r.addr = word_addr;
                    r.ctl  = CTL_WRITE;
                    r.data = t.wword;
                    if (!t.ssyn) raise_msyn(1'b1, t, r);
                end
                PH_WAIT_RD, PH_WAIT_WR: begin
                    wr     = (seq_phase == PH_WAIT_WR);
                    done   = t.ssyn;
                    r.addr = word_addr;
                    r.ctl  = wr ? CTL_WRITE : CTL_READ;
                    r.msyn = 1'b1;
                    r.data = wr ? t.wword : 16'h0000;
                    if (!done) begin
                        if (wait_cnt <= 1) begin
                            timed_out = 1'b1;
                            done      = 1'b1;
                        end else begin
                            wait_cnt = wait_cnt - 16'd1;
                        end
                    end
                    if (done) begin
                        r.msyn = 1'b0;
                        r.data = '0;
                        // a timed-out read still latches the bus data
                        if (!wr) begin
                            r.bwr   = 1'b1;
                            r.bdata = t.bdin;
                        end
                        seq_phase = PH_FINISH;
                    end
                end
                PH_FINISH: begin
                    r.addr = word_addr;
                    r.ctl  = cfg_kind[KIND_WRITE_BIT] ? CTL_WRITE : CTL_READ;
                    if (timed_out) begin
                        release_bus(ST_TIMEOUT, 1'b1, r);
                    end else begin
                        words_left = words_left - 16'd1;
                        word_idx   = word_idx + 16'd1;
                        if (words_left == 0) release_bus(ST_READY, 1'b0, r);
                        else if (t.init) release_bus(ST_INIT, 1'b1, r);
                        else begin
                            word_addr = word_addr + ADDR_STEP;
                            seq_phase = PH_DRIVE;
                        end
                    end
                end
                default: seq_phase = PH_IDLE;
            endcase
        end
        r.sack   = sack_q;
        r.bbsy   = bbsy_q;
        r.status = run_st;
        r.bidx   = word_idx;
    endtask

    function automatic tick_t make_tick(input logic mode, input logic ssyn,
                                        input logic init, input logic hit);
        tick_t t;
        t.mode  = mode;
        t.ssyn  = ssyn;
        t.init  = init;
        t.hit   = hit;
        t.ird   = 16'($urandom);
        t.bdin  = 16'($urandom);
        t.wword = 16'($urandom);
        return t;
    endfunction

    // present one item, wait until it is taken, then queue its prediction
    task automatic send_tick(input tick_t t);
        int unsigned gap;
        lines_t      want;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, t.wword, t.bdin, t.ird, t.hit, t.init, t.ssyn};
        s_tuser  <= t.mode;
        do @(posedge aclk); while (!s_tready);
        predict_bus_lines(t, want);
        expected_q.push_back(want);
    endtask

    // register write, only once every owed result has come back
    task automatic write_reg(input cfg_idx_t idx, input logic [17:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_ADDRESS: cfg_start = value;
            CFG_WORD_COUNT:    cfg_count = value[15:0];
            CFG_CYCLE_KIND:    cfg_kind  = value[1:0];
            default:           cfg_ticks = value[15:0];
        endcase
    endtask

    // sink pacing: random stalls on m_tready
    always @(posedge aclk) begin : sink_pacing
        int unsigned g;
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left  = stall_left - 1;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left  = g - 1;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // every accepted result is matched against the oldest prediction
    always @(posedge aclk) begin : result_check
        lines_t want;
        lines_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.addr   = m_tdata[17:0];
            got.ctl    = m_tdata[19:18];
            got.msyn   = m_tdata[20];
            got.data   = m_tdata[36:21];
            got.sack   = m_tdata[37];
            got.bbsy   = m_tdata[38];
            got.status = m_tdata[40:39];
            got.bwr    = m_tdata[41];
            got.bidx   = m_tdata[57:42];
            got.bdata  = m_tdata[73:58];
            got.iwr    = m_tdata[75:74];
            got.idata  = m_tdata[91:76];
            if (expected_q.size() == 0) begin
                $error("result item with no prediction waiting: 0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                compare_field("bus_address", want.addr, got.addr);
                compare_field("bus_control", want.ctl, got.ctl);
                compare_field("msyn_out", want.msyn, got.msyn);
                compare_field("data_lines", want.data, got.data);
                compare_field("sack_out", want.sack, got.sack);
                compare_field("bbsy_out", want.bbsy, got.bbsy);
                compare_field("status", want.status, got.status);
                compare_field("buffer_write", want.bwr, got.bwr);
                compare_field("buffer_index", want.bidx, got.bidx);
                compare_field("buffer_data", want.bdata, got.bdata);
                compare_field("internal_write", want.iwr, got.iwr);
                compare_field("internal_write_data", want.idata, got.idata);
            end
        end
    end

    // hang detector: no handshake on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reset_shadow();
        cfg_start  = '0;
        cfg_count  = '0;
        cfg_kind   = '0;
        cfg_ticks  = TIMEOUT_RESET;
        seq_phase  = PH_IDLE;
        word_addr  = '0;
        words_left = '0;
        word_idx   = '0;
        wait_cnt   = '0;
        timed_out  = 1'b0;
        run_st     = ST_READY;
        // arbitration is taken as already won out of reset
        sack_q     = 1'b1;
        bbsy_q     = 1'b1;
    endtask

    // ticks before any start: lines stay released, nothing moves
    task automatic test_idle_ticks();
        send_tick('0);
        send_tick({1'b0, {(S_TDATA_W - 5){1'b1}}});
    endtask

    // zero word count ends on the first tick with ready status
    task automatic test_zero_count();
        write_reg(CFG_WORD_COUNT, 18'd0);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1));
    endtask

    // internal slave reads at the top of the address space, wrapping to zero
    task automatic test_internal_read_wrap();
        write_reg(CFG_START_ADDRESS, 18'h3FFFE);
        write_reg(CFG_WORD_COUNT, 18'd2);
        write_reg(CFG_CYCLE_KIND, 18'd0);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    // external read answered by ssyn then stopped by init, then a timed-out read
    task automatic test_external_read_stops();
        write_reg(CFG_START_ADDRESS, 18'h00000);
        write_reg(CFG_CYCLE_KIND, 18'd1);
        write_reg(CFG_TIMEOUT_TICKS, 18'd2);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0));
    endtask

    // byte writes: ssyn still high from the last cycle, upper byte, zero timeout
    task automatic test_byte_writes();
        write_reg(CFG_START_ADDRESS, 18'h00001);
        write_reg(CFG_CYCLE_KIND, 18'd3);
        write_reg(CFG_TIMEOUT_TICKS, 18'd0);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // word writes at the register extremes, with a restart mid-transfer
    task automatic test_word_write_restart();
        write_reg(CFG_START_ADDRESS, 18'h3FFFF);
        write_reg(CFG_WORD_COUNT, 18'd65535);
        write_reg(CFG_CYCLE_KIND, 18'd2);
        write_reg(CFG_TIMEOUT_TICKS, 18'd65535);
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // random transfers: mostly well-formed runs, with restarts, init and stray ticks
    task automatic test_random_transfers(input int unsigned target);
        int unsigned busy_items;
        int unsigned run_len;
        int unsigned pct;
        logic [17:0] value;
        logic        mode;
        logic        ssyn;
        busy_items = 0;
        while (busy_items < target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                // some starts just below the top so the address wraps
                value = ($urandom_range(0, 4) == 0) ? 18'h3FFF0 + 18'($urandom_range(0, 15))
                                                    : 18'($urandom);
                write_reg(CFG_START_ADDRESS, value);
            end
            if ($urandom_range(0, 3) != 0) begin
                pct = $urandom_range(0, 99);
                if (pct < 70) value = 18'($urandom_range(0, 4));
                else if (pct < 95) value = 18'($urandom_range(5, 16));
                else value = 18'($urandom_range(17, 65535));
                write_reg(CFG_WORD_COUNT, value);
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_CYCLE_KIND, 18'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0) begin
                pct = $urandom_range(0, 99);
                if (pct < 60) value = 18'($urandom_range(1, 4));
                else if (pct < 90) value = 18'($urandom_range(5, 12));
                else if (pct < 95) value = 18'd65535;
                else value = 18'($urandom_range(1, 65535));
                write_reg(CFG_TIMEOUT_TICKS, value);
            end
            repeat ($urandom_range(1, 4)) begin
                // stray service tick outside a transfer
                if ($urandom_range(0, 9) == 0)
                    send_tick(make_tick(1'b0, 1'($urandom), 1'($urandom), 1'($urandom)));
                send_tick(make_tick(1'b1, 1'($urandom), 1'($urandom), 1'($urandom)));
                busy_items++;
                run_len = 0;
                while (seq_phase != PH_IDLE && run_len < 64) begin
                    mode = ($urandom_range(0, 49) == 0);
                    pct  = (seq_phase == PH_WAIT_RD || seq_phase == PH_WAIT_WR) ? 45 : 30;
                    ssyn = ($urandom_range(0, 99) < pct);
                    send_tick(make_tick(mode, ssyn, $urandom_range(0, 11) == 0,
                                        1'($urandom)));
                    busy_items++;
                    run_len++;
                end
            end
        end
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_ticks();
        test_zero_count();
        test_internal_read_wrap();
        test_external_read_stops();
        test_byte_writes();
        test_word_write_restart();
        test_random_transfers(1650);

        // let every owed result come back, then watch a little longer
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/udms_pkg.sv
src/unibus_dma_master_sequencer_core.sv
test/tb.sv
